// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DMS_ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DMS_ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define DMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/dms_pkg.sv =====
// Types, codes and helper functions of the moment statistics block.
package dms_pkg;

  localparam int unsigned WIDE_W = 128;
  localparam int unsigned HALF_W = 64;

  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_ANALYZE = 2'd2;

  localparam logic [3:0] STAT_MEAN  = 4'd0;
  localparam logic [3:0] STAT_MAD   = 4'd1;
  localparam logic [3:0] STAT_VAR   = 4'd2;
  localparam logic [3:0] STAT_SD    = 4'd3;
  localparam logic [3:0] STAT_CV    = 4'd4;
  localparam logic [3:0] STAT_HOMOG = 4'd5;
  localparam logic [3:0] STAT_ZS    = 4'd6;
  localparam logic [3:0] STAT_SKEW  = 4'd7;
  localparam logic [3:0] STAT_KURT  = 4'd8;

  localparam logic [127:0] CV_LIMIT = 128'd10 << 32;
  localparam logic [63:0]  Z_CLIP   = 64'd1 << 47;
  localparam logic [63:0]  PERCENT  = 64'd100;

  typedef enum logic [5:0] {
    S_IDLE, S_SUM_RD, S_SUM_ACC, S_NN, S_NN_W, S_MEAN, S_MEAN_W, S_EMIT,
    S_DEV_RD, S_DEV_LD, S_DEV_MW, S_P2_SQ, S_P2_SQW, S_MAD, S_MAD_W,
    S_VAR, S_NNM_W, S_VAR_W, S_SQ_W, S_CV, S_CV_M, S_CV_W, S_ZS, S_ZS_M,
    S_DEN_W, S_ZS_W, S_Z, S_Z_W, S_Z2_W, S_Z3_W, S_Z4_W, S_SK, S_SK_W,
    S_KU, S_KU_W
  } st_e;

  typedef struct packed {
    logic [63:0] val;
    logic        sat;
  } sat_t;

  function automatic sat_t sat_f(input logic neg, input logic [127:0] mag);
    sat_t r;
    if (!neg && (mag[127:64] != 64'd0 || mag[63])) begin
      r.val = {1'b0, {63{1'b1}}};
      r.sat = 1'b1;
    end else if (neg && (mag[127:64] != 64'd0 || mag[63:0] > (64'd1 << 63))) begin
      r.val = {1'b1, 63'd0};
      r.sat = 1'b1;
    end else begin
      r.val = neg ? (64'd0 - mag[63:0]) : mag[63:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag_f(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ===== hdl/dataset_moment_statistics_top.sv =====
// Top level of the moment statistics block: sequencer, datapath and output register.
// Input words arrive on s_axis: tuser carries the kind (append, clear, analyze),
// tdata carries the sample in bits 31:0 and the query value in bits 63:32.
// An append or clear word is taken while idle and gives no result; a sample
// sent while the store already holds MAX_OBSERVATIONS samples is dropped.
// An analyze word gives nine result words on m_axis in fixed order: mean, mad,
// variance, stddev, cv, homogeneity flag, z-score, skewness and kurtosis.
// tdata is Q32.32 for cv, z-score, skewness, kurtosis, Q48.16 for mean, mad, stddev
// and integer otherwise; tuser holds id[3:0], saturation[4]; tlast marks kurtosis.
// The time one analysis takes grows with the number n of stored samples. It is set
// by the shared 128-bit divider, used seven times and once more per sample in the
// skewness pass, by the products on the shared multiplier and by the square root.
// s_axis_tready_o is low for the whole analysis. Results wait in a one-word output
// register; a stalled receiver holds the sequencer until it is taken. Reset empties
// the dataset, sets sample_mode to 1 and drops any pending word. cfg_we_i writes
// sample_mode from cfg_wdata_i; the user must do so only while idle (not enforced).
`include "assert_macros.svh"
module dataset_moment_statistics_top #(
  parameter int unsigned MAX_OBSERVATIONS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // sample[31:0], query_value[63:32]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // stat_value[63:0]
  output logic [4:0]  m_axis_tuser_o,   // stat_id[3:0], saturated[4]
  output logic        m_axis_tlast_o
);

  localparam int unsigned CW = $clog2(MAX_OBSERVATIONS + 1);
  localparam int unsigned AW = $clog2(MAX_OBSERVATIONS);

  dms_pkg::st_e state_q, state_d;

  logic [CW-1:0]  cnt_q, idx_q;
  logic           mode_q, pass3_q, xneg_q;
  logic [31:0]    query_q, rdata;
  logic [63:0]    s_q, nn_q, mean_q, abs_q, sd_q, d_q, nq_q, z_q, z2_q;
  logic [127:0]   m2_q, var_q, cv_q, den_q, p3_q, n3_q, s4_q, res_q;
  logic           cv_neg_q, res_neg_q;
  logic [3:0]     em_id_q;

  logic           out_valid_q, out_sat_q;
  logic [3:0]     out_id_q;
  logic [63:0]    out_val_q;

  logic           in_acc, full, mem_we, out_load;
  logic           mul_start, mul_done, div_start, div_done, sq_start, sq_done;
  logic [63:0]    mul_a, mul_b, sq_root;
  logic [127:0]   mul_p, div_n, div_d, div_q, sq_a;

  logic [63:0]    n64, sabs, x64, xmag, q64, qmag, dmag, nqmag, np_s, dev, nq, zclip;
  logic [63:0]    m64, z2_new;
  logic [127:0]   z3_new, em_mag;
  logic           var_ok, homog, em_neg, sk_neg;
  dms_pkg::sat_t  em_sat;

  assign n64    = {{(64-CW){1'b0}}, cnt_q};
  assign sabs   = dms_pkg::mag_f(s_q);
  assign x64    = {{32{rdata[31]}}, rdata};
  assign xmag   = dms_pkg::mag_f(x64);
  assign q64    = {{32{query_q[31]}}, query_q};
  assign qmag   = dms_pkg::mag_f(q64);
  assign dmag   = dms_pkg::mag_f(d_q);
  assign nqmag  = dms_pkg::mag_f(nq_q);
  assign np_s   = xneg_q ? (64'd0 - mul_p[63:0]) : mul_p[63:0];
  assign dev    = np_s - s_q;
  assign nq     = (query_q[31] ? (64'd0 - mul_p[63:0]) : mul_p[63:0]) - s_q;
  assign zclip  = (div_q[127:64] != 64'd0 || div_q[63:0] > dms_pkg::Z_CLIP) ?
                  dms_pkg::Z_CLIP : div_q[63:0];
  assign z2_new = mul_p[95:32];
  assign z3_new = {32'd0, mul_p[127:32]};
  assign var_ok = (cnt_q > CW'(1)) || (cnt_q == CW'(1) && !mode_q);
  assign m64    = mode_q ? (n64 - 64'd1) : n64;
  assign homog  = cv_neg_q || (cv_q < dms_pkg::CV_LIMIT);
  assign sk_neg = (p3_q < n3_q);

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign full   = (cnt_q >= CW'(MAX_OBSERVATIONS));
  assign mem_we = in_acc && (s_axis_tuser_i == dms_pkg::KIND_APPEND) && !full;

  dms_store #(.DEPTH(MAX_OBSERVATIONS)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i[31:0]),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  dms_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  dms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  dms_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .a_i     (sq_a),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    case (em_id_q)
      dms_pkg::STAT_MEAN:  begin em_neg = s_q[63];   em_mag = {64'd0, mean_q}; end
      dms_pkg::STAT_VAR:   begin em_neg = 1'b0;      em_mag = var_q;           end
      dms_pkg::STAT_SD:    begin em_neg = 1'b0;      em_mag = {64'd0, sd_q};   end
      dms_pkg::STAT_CV:    begin em_neg = cv_neg_q;  em_mag = cv_q;            end
      dms_pkg::STAT_HOMOG: begin em_neg = 1'b0;      em_mag = {127'd0, homog}; end
      default:             begin em_neg = res_neg_q; em_mag = res_q;           end
    endcase
  end

  assign em_sat = dms_pkg::sat_f(em_neg, em_mag);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dms_pkg::S_IDLE:
        if (in_acc && s_axis_tuser_i == dms_pkg::KIND_ANALYZE) state_d = dms_pkg::S_SUM_RD;
      dms_pkg::S_SUM_RD:
        state_d = (idx_q == cnt_q) ? dms_pkg::S_NN : dms_pkg::S_SUM_ACC;
      dms_pkg::S_SUM_ACC: state_d = dms_pkg::S_SUM_RD;
      dms_pkg::S_NN:      state_d = dms_pkg::S_NN_W;
      dms_pkg::S_NN_W:    if (mul_done) state_d = dms_pkg::S_MEAN;
      dms_pkg::S_MEAN:    state_d = dms_pkg::S_MEAN_W;
      dms_pkg::S_MEAN_W:  if (div_done) state_d = dms_pkg::S_EMIT;
      dms_pkg::S_EMIT:
        if (out_load) begin
          case (em_id_q)
            dms_pkg::STAT_MEAN:  state_d = dms_pkg::S_DEV_RD;
            dms_pkg::STAT_MAD:   state_d = dms_pkg::S_VAR;
            dms_pkg::STAT_VAR:   state_d = dms_pkg::S_EMIT;
            dms_pkg::STAT_SD:    state_d = dms_pkg::S_CV;
            dms_pkg::STAT_CV:    state_d = dms_pkg::S_EMIT;
            dms_pkg::STAT_HOMOG: state_d = dms_pkg::S_ZS;
            dms_pkg::STAT_ZS:
              state_d = (sd_q == 64'd0) ? dms_pkg::S_SK : dms_pkg::S_DEV_RD;
            dms_pkg::STAT_SKEW:  state_d = dms_pkg::S_KU;
            default:             state_d = dms_pkg::S_IDLE;
          endcase
        end
      dms_pkg::S_DEV_RD:
        if (idx_q == cnt_q) state_d = pass3_q ? dms_pkg::S_SK : dms_pkg::S_MAD;
        else state_d = dms_pkg::S_DEV_LD;
      dms_pkg::S_DEV_LD:  state_d = dms_pkg::S_DEV_MW;
      dms_pkg::S_DEV_MW:
        if (mul_done) state_d = pass3_q ? dms_pkg::S_Z : dms_pkg::S_P2_SQ;
      dms_pkg::S_P2_SQ:   state_d = dms_pkg::S_P2_SQW;
      dms_pkg::S_P2_SQW:  if (mul_done) state_d = dms_pkg::S_DEV_RD;
      dms_pkg::S_MAD:     state_d = dms_pkg::S_MAD_W;
      dms_pkg::S_MAD_W:   if (div_done) state_d = dms_pkg::S_EMIT;
      dms_pkg::S_VAR:     state_d = var_ok ? dms_pkg::S_NNM_W : dms_pkg::S_EMIT;
      dms_pkg::S_NNM_W:   if (mul_done) state_d = dms_pkg::S_VAR_W;
      dms_pkg::S_VAR_W:   if (div_done) state_d = dms_pkg::S_SQ_W;
      dms_pkg::S_SQ_W:    if (sq_done) state_d = dms_pkg::S_EMIT;
      dms_pkg::S_CV:
        state_d = (sd_q != 64'd0 && mean_q != 64'd0) ? dms_pkg::S_CV_M : dms_pkg::S_EMIT;
      dms_pkg::S_CV_M:    if (mul_done) state_d = dms_pkg::S_CV_W;
      dms_pkg::S_CV_W:    if (div_done) state_d = dms_pkg::S_EMIT;
      dms_pkg::S_ZS:      state_d = dms_pkg::S_ZS_M;
      dms_pkg::S_ZS_M:
        if (mul_done) state_d = (sd_q != 64'd0) ? dms_pkg::S_DEN_W : dms_pkg::S_EMIT;
      dms_pkg::S_DEN_W:   if (mul_done) state_d = dms_pkg::S_ZS_W;
      dms_pkg::S_ZS_W:    if (div_done) state_d = dms_pkg::S_EMIT;
      dms_pkg::S_Z:       state_d = dms_pkg::S_Z_W;
      dms_pkg::S_Z_W:     if (div_done) state_d = dms_pkg::S_Z2_W;
      dms_pkg::S_Z2_W:    if (mul_done) state_d = dms_pkg::S_Z3_W;
      dms_pkg::S_Z3_W:    if (mul_done) state_d = dms_pkg::S_Z4_W;
      dms_pkg::S_Z4_W:    if (mul_done) state_d = dms_pkg::S_DEV_RD;
      dms_pkg::S_SK:      state_d = (sd_q == 64'd0) ? dms_pkg::S_EMIT : dms_pkg::S_SK_W;
      dms_pkg::S_SK_W:    if (div_done) state_d = dms_pkg::S_EMIT;
      dms_pkg::S_KU:      state_d = (sd_q == 64'd0) ? dms_pkg::S_EMIT : dms_pkg::S_KU_W;
      dms_pkg::S_KU_W:    if (div_done) state_d = dms_pkg::S_EMIT;
      default:            state_d = dms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == dms_pkg::S_IDLE);
    out_load  = (state_q == dms_pkg::S_EMIT) && (!out_valid_q || m_axis_tready_i);
    mul_start = 1'b0;
    mul_a     = 64'd0;
    mul_b     = 64'd0;
    div_start = 1'b0;
    div_n     = 128'd0;
    div_d     = 128'd0;
    sq_start  = 1'b0;
    sq_a      = 128'd0;
    case (state_q)
      dms_pkg::S_NN: begin
        mul_start = 1'b1; mul_a = n64; mul_b = n64;
      end
      dms_pkg::S_MEAN: begin
        div_start = 1'b1; div_n = {64'd0, sabs[47:0], 16'd0}; div_d = {64'd0, n64};
      end
      dms_pkg::S_DEV_LD: begin
        mul_start = 1'b1; mul_a = n64; mul_b = xmag;
      end
      dms_pkg::S_P2_SQ: begin
        mul_start = 1'b1; mul_a = dmag; mul_b = dmag;
      end
      dms_pkg::S_MAD: begin
        div_start = 1'b1; div_n = {48'd0, abs_q, 16'd0}; div_d = {64'd0, nn_q};
      end
      dms_pkg::S_VAR: begin
        mul_start = var_ok; mul_a = nn_q; mul_b = m64;
      end
      dms_pkg::S_NNM_W: begin
        div_start = mul_done; div_n = m2_q; div_d = mul_p;
      end
      dms_pkg::S_VAR_W: begin
        sq_start = div_done; sq_a = {div_q[95:0], 32'd0};
      end
      dms_pkg::S_CV: begin
        mul_start = (sd_q != 64'd0 && mean_q != 64'd0); mul_a = sd_q; mul_b = dms_pkg::PERCENT;
      end
      dms_pkg::S_CV_M: begin
        div_start = mul_done; div_n = {32'd0, mul_p[63:0], 32'd0}; div_d = {64'd0, mean_q};
      end
      dms_pkg::S_ZS: begin
        mul_start = 1'b1; mul_a = n64; mul_b = qmag;
      end
      dms_pkg::S_ZS_M: begin
        mul_start = mul_done && (sd_q != 64'd0); mul_a = n64; mul_b = sd_q;
      end
      dms_pkg::S_DEN_W: begin
        div_start = mul_done; div_n = {64'd0, nqmag} << 48; div_d = mul_p;
      end
      dms_pkg::S_Z: begin
        div_start = 1'b1; div_n = {64'd0, dmag} << 48; div_d = den_q;
      end
      dms_pkg::S_Z_W: begin
        mul_start = div_done; mul_a = zclip; mul_b = zclip;
      end
      dms_pkg::S_Z2_W: begin
        mul_start = mul_done; mul_a = z2_new; mul_b = z_q;
      end
      dms_pkg::S_Z3_W: begin
        mul_start = mul_done; mul_a = z2_q; mul_b = z2_q;
      end
      dms_pkg::S_SK: begin
        div_start = (sd_q != 64'd0);
        div_n     = sk_neg ? (n3_q - p3_q) : (p3_q - n3_q);
        div_d     = {64'd0, n64};
      end
      dms_pkg::S_KU: begin
        div_start = (sd_q != 64'd0); div_n = s4_q; div_d = {64'd0, n64};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dms_pkg::S_IDLE;
      cnt_q       <= '0;
      mode_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (in_acc && s_axis_tuser_i == dms_pkg::KIND_CLEAR) begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q  <= em_id_q;
      out_val_q <= em_sat.val;
      out_sat_q <= em_sat.sat;
    end
    case (state_q)
      dms_pkg::S_IDLE: begin
        query_q <= s_axis_tdata_i[63:32];
        s_q     <= 64'd0;
        idx_q   <= '0;
      end
      dms_pkg::S_SUM_ACC: begin
        s_q   <= s_q + x64;
        idx_q <= idx_q + 1'b1;
      end
      dms_pkg::S_NN_W:
        if (mul_done) nn_q <= mul_p[63:0];
      dms_pkg::S_MEAN_W:
        if (div_done) begin
          mean_q  <= div_q[63:0];
          em_id_q <= dms_pkg::STAT_MEAN;
        end
      dms_pkg::S_EMIT:
        if (out_load) begin
          case (em_id_q)
            dms_pkg::STAT_MEAN: begin
              idx_q <= '0; abs_q <= 64'd0; m2_q <= 128'd0; pass3_q <= 1'b0;
            end
            dms_pkg::STAT_VAR: em_id_q <= dms_pkg::STAT_SD;
            dms_pkg::STAT_CV:  em_id_q <= dms_pkg::STAT_HOMOG;
            dms_pkg::STAT_ZS: begin
              idx_q <= '0; p3_q <= 128'd0; n3_q <= 128'd0; s4_q <= 128'd0;
              pass3_q <= 1'b1;
            end
            default: em_id_q <= em_id_q;
          endcase
        end
      dms_pkg::S_DEV_LD:
        xneg_q <= rdata[31];
      dms_pkg::S_DEV_MW:
        if (mul_done) d_q <= dev;
      dms_pkg::S_P2_SQ:
        abs_q <= abs_q + dmag;
      dms_pkg::S_P2_SQW:
        if (mul_done) begin
          m2_q  <= m2_q + mul_p;
          idx_q <= idx_q + 1'b1;
        end
      dms_pkg::S_MAD_W:
        if (div_done) begin
          res_q <= div_q; res_neg_q <= 1'b0; em_id_q <= dms_pkg::STAT_MAD;
        end
      dms_pkg::S_VAR:
        if (!var_ok) begin
          var_q <= 128'd0; sd_q <= 64'd0; em_id_q <= dms_pkg::STAT_VAR;
        end
      dms_pkg::S_VAR_W:
        if (div_done) var_q <= div_q;
      dms_pkg::S_SQ_W:
        if (sq_done) begin
          sd_q <= sq_root; em_id_q <= dms_pkg::STAT_VAR;
        end
      dms_pkg::S_CV:
        if (!(sd_q != 64'd0 && mean_q != 64'd0)) begin
          cv_q <= 128'd0; cv_neg_q <= 1'b0; em_id_q <= dms_pkg::STAT_CV;
        end
      dms_pkg::S_CV_W:
        if (div_done) begin
          cv_q     <= div_q;
          cv_neg_q <= s_q[63] && (div_q != 128'd0);
          em_id_q  <= dms_pkg::STAT_CV;
        end
      dms_pkg::S_ZS_M:
        if (mul_done) begin
          nq_q <= nq;
          if (sd_q == 64'd0) begin
            res_q <= 128'd0; res_neg_q <= 1'b0; em_id_q <= dms_pkg::STAT_ZS;
          end
        end
      dms_pkg::S_DEN_W:
        if (mul_done) den_q <= mul_p;
      dms_pkg::S_ZS_W:
        if (div_done) begin
          res_q     <= div_q;
          res_neg_q <= nq_q[63] && (div_q != 128'd0);
          em_id_q   <= dms_pkg::STAT_ZS;
        end
      dms_pkg::S_Z_W:
        if (div_done) z_q <= zclip;
      dms_pkg::S_Z2_W:
        if (mul_done) z2_q <= z2_new;
      dms_pkg::S_Z3_W:
        if (mul_done) begin
          if (d_q[63]) n3_q <= n3_q + z3_new;
          else p3_q <= p3_q + z3_new;
        end
      dms_pkg::S_Z4_W:
        if (mul_done) begin
          s4_q  <= s4_q + z3_new;
          idx_q <= idx_q + 1'b1;
        end
      dms_pkg::S_SK:
        if (sd_q == 64'd0) begin
          res_q <= 128'd0; res_neg_q <= 1'b0; em_id_q <= dms_pkg::STAT_SKEW;
        end
      dms_pkg::S_SK_W:
        if (div_done) begin
          res_q     <= div_q;
          res_neg_q <= sk_neg && (div_q != 128'd0);
          em_id_q   <= dms_pkg::STAT_SKEW;
        end
      dms_pkg::S_KU:
        if (sd_q == 64'd0) begin
          res_q <= 128'd0; res_neg_q <= 1'b0; em_id_q <= dms_pkg::STAT_KURT;
        end
      dms_pkg::S_KU_W:
        if (div_done) begin
          res_q <= div_q; res_neg_q <= 1'b0; em_id_q <= dms_pkg::STAT_KURT;
        end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = {out_sat_q, out_id_q};
  assign m_axis_tlast_o  = (out_id_q == dms_pkg::STAT_KURT);

  `DMS_ASSERT_NEXT(a_busy_after_analyze, clk_i, rst_ni, in_acc && s_axis_tuser_i == dms_pkg::KIND_ANALYZE, !s_axis_tready_o, "input ready during analysis")
  `DMS_ASSERT_HOLDS(a_count_bound, clk_i, rst_ni, cnt_q <= CW'(MAX_OBSERVATIONS), "count above store depth")
  `DMS_ASSERT_NEXT(a_full_drop, clk_i, rst_ni, in_acc && s_axis_tuser_i == dms_pkg::KIND_APPEND && full, cnt_q == CW'(MAX_OBSERVATIONS), "append into full store changed count")
  `DMS_ASSERT_HOLDS(a_units_exclusive, clk_i, rst_ni, !(mul_done && div_done) && !(sq_done && mul_done), "two shared units finished together")

endmodule

// ===== hdl/dms_store.sv =====
// Observation memory with one write port and one registered read port.
module dms_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [31:0]              wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [31:0]              rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/dms_mul.sv =====
// Shared 64 by 64 multiplier built from four 32 by 32 partial products.
module dms_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);

  logic [63:0]  a_q, b_q, pp_q;
  logic [1:0]   sh_q;
  logic [2:0]   step_q;
  logic         busy_q, done_q;
  logic [127:0] acc_q, pp_sh;
  logic [31:0]  opa, opb;

  assign opa = step_q[0] ? a_q[63:32] : a_q[31:0];
  assign opb = step_q[1] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    pp_sh = {64'd0, pp_q};
      2'd1:    pp_sh = {32'd0, pp_q, 32'd0};
      2'd2:    pp_sh = {pp_q, 64'd0};
      default: pp_sh = 128'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        pp_q <= opa * opb;
        sh_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== hdl/dms_div.sv =====
// Shared 128-bit unsigned restoring divider, one quotient bit per cycle.
module dms_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [127:0] den_i,
  output logic         done_o,
  output logic [127:0] q_o
);

  localparam int unsigned W  = dms_pkg::WIDE_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  num_q, den_q, rem_q, quo_q;
  logic [W:0]    trial, diff;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, dz_q, fit;

  assign trial = {rem_q, num_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fit   = !diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      dz_q  <= (den_i == '0);
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], 1'b0};
      rem_q <= fit ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign q_o    = dz_q ? '0 : quo_q;

endmodule

// ===== hdl/dms_isqrt.sv =====
// Integer square root of a 128-bit value, two radicand bits per cycle.
module dms_isqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] a_i,
  output logic         done_o,
  output logic [63:0]  root_o
);

  localparam int unsigned R  = dms_pkg::HALF_W;
  localparam int unsigned CW = $clog2(R + 1);

  logic [2*R-1:0] a_q;
  logic [R+1:0]   rem_q;
  logic [R+3:0]   rr, tr, df;
  logic [R-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q, fit;

  assign rr  = {rem_q, a_q[2*R-1:2*R-2]};
  assign tr  = {2'b00, root_q, 2'b01};
  assign df  = rr - tr;
  assign fit = (rr >= tr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(R);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      a_q    <= {a_q[2*R-3:0], 2'b00};
      rem_q  <= fit ? df[R+1:0] : rr[R+1:0];
      root_q <= {root_q[R-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
